/* src/wmcd_pkg.sv */
// ----------------------------------------------------------------------------
// Weighted modulus check digit: shared package
// Widths, register indexes and the types that pass between the lanes, the
// merging adder tree and the remainder pipeline.
// ----------------------------------------------------------------------------
package wmcd_pkg;

	localparam int NUM_DIGITS = 10;
	localparam int DIGIT_W    = 4;
	localparam int WEIGHT_W   = 4;
	// A product of two 4-bit values fits in 8 bits; so does a cross sum.
	localparam int PROD_W     = 8;
	// Ten 8-bit values sum to at most 2550, which fits in 12 bits.
	localparam int SUM_W      = 12;
	// Wide enough for the largest shifted divisor (15 << 11).
	localparam int REM_CMP_W  = 16;
	localparam int MOD_W      = 4;
	localparam int POS_W      = 4;
	localparam int WTAB_W     = NUM_DIGITS * WEIGHT_W;

	// Exact floor(p / 10) for p below 1029 as (p * 205) >> 11.
	localparam int RECIP_10   = 205;
	localparam int RECIP_SH   = 11;

	localparam logic [DIGIT_W-1:0] CHECK_BASE = 4'd10;
	localparam logic [POS_W-1:0]   POS_FIRST  = 4'd1;
	localparam logic [POS_W-1:0]   POS_LAST   = 4'd10;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_MODULUS   = 2'd0;
	localparam logic [1:0] REG_WEIGHTS   = 2'd1;
	localparam logic [1:0] REG_CROSS_SUM = 2'd2;
	localparam logic [1:0] REG_CHECK_POS = 2'd3;

	typedef logic [NUM_DIGITS-1:0][PROD_W-1:0] lane_vals_t;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
	} lane_ctl_t;

	typedef struct packed {
		logic                ok;
		logic [DIGIT_W-1:0] digit;
	} chk_ref_t;

endpackage

/* src/wmcd_lane.sv */
// ----------------------------------------------------------------------------
// Weighted modulus check digit: digit lane
// Multiplies one digit by its weight, then optionally folds the product into
// its tens plus units. Two pipeline stages.
// ----------------------------------------------------------------------------
module wmcd_lane (
	input  logic                            clk,
	input  wmcd_pkg::lane_ctl_t             ctl,
	input  logic [wmcd_pkg::DIGIT_W-1:0]    digit,
	input  logic [wmcd_pkg::WEIGHT_W-1:0]   weight,
	input  logic                            cross_en,
	output logic [wmcd_pkg::PROD_W-1:0]     value_s2
);

	logic [wmcd_pkg::PROD_W-1:0]   prod_s1;
	logic [2*wmcd_pkg::PROD_W-1:0] prod_x;
	logic [4:0]                    tens;
	logic [wmcd_pkg::PROD_W-1:0]   tens10;
	logic [wmcd_pkg::PROD_W-1:0]   units;
	logic [4:0]                    cross_sum;

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			prod_s1 <= {4'b0000, digit} * {4'b0000, weight};
		end
	end

	// Tens digit by reciprocal multiplication, units by subtracting ten times it.
	always_comb begin
		prod_x    = {8'h00, prod_s1} * 16'(wmcd_pkg::RECIP_10);
		tens      = prod_x[wmcd_pkg::RECIP_SH +: 5];
		tens10    = {tens, 3'b000} + {2'b00, tens, 1'b0};
		units     = prod_s1 - tens10;
		cross_sum = tens + {1'b0, units[3:0]};
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			value_s2 <= cross_en ? {3'b000, cross_sum} : prod_s1;
		end
	end

endmodule

/* src/wmcd_merge.sv */
// ----------------------------------------------------------------------------
// Weighted modulus check digit: merging adder tree
// Sums the ten lane values in one registered stage.
// ----------------------------------------------------------------------------
module wmcd_merge (
	input  logic                           clk,
	input  logic                           en,
	input  wmcd_pkg::lane_vals_t           vals,
	output logic [wmcd_pkg::SUM_W-1:0]     sum_s3
);

	localparam int NUM_PAIRS = wmcd_pkg::NUM_DIGITS / 2;

	logic [wmcd_pkg::PROD_W:0]   pair [NUM_PAIRS];
	logic [wmcd_pkg::SUM_W-1:0]  total;

	always_comb begin
		for (int i = 0; i < NUM_PAIRS; i++) begin
			pair[i] = {1'b0, vals[2*i]} + {1'b0, vals[2*i+1]};
		end
		total = '0;
		for (int i = 0; i < NUM_PAIRS; i++) begin
			total = total + wmcd_pkg::SUM_W'(pair[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3 <= total;
		end
	end

endmodule

/* src/wmcd_rem_step.sv */
// ----------------------------------------------------------------------------
// Weighted modulus check digit: remainder stage
// Four restoring compare-and-subtract steps of the remainder, divisor shifted
// by SHIFT_HI down to SHIFT_HI-3, followed by a register.
// ----------------------------------------------------------------------------
module wmcd_rem_step #(
	parameter int SHIFT_HI = 11
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [wmcd_pkg::SUM_W-1:0]    rem_in,
	input  logic [wmcd_pkg::MOD_W-1:0]    modulus,
	output logic [wmcd_pkg::SUM_W-1:0]    rem_q
);

	localparam int STEPS = 4;

	logic [wmcd_pkg::REM_CMP_W-1:0] r;
	logic [wmcd_pkg::REM_CMP_W-1:0] dvs;

	always_comb begin
		r   = wmcd_pkg::REM_CMP_W'(rem_in);
		dvs = '0;
		for (int k = 0; k < STEPS; k++) begin
			dvs = wmcd_pkg::REM_CMP_W'(modulus) << (SHIFT_HI - k);
			if (r >= dvs) begin
				r = r - dvs;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= r[wmcd_pkg::SUM_W-1:0];
		end
	end

endmodule

/* src/weighted_modulus_check_digit.sv */
// ----------------------------------------------------------------------------
// Weighted modulus check digit
// Checks a ten-digit account number against a configurable weighted modulus
// scheme and returns the computed check digit and a pass flag.
// ----------------------------------------------------------------------------
// The block accepts one request per clock cycle while req_ready is high.
// Each request carries ten digits; ten lanes multiply every
// digit by its weight and optionally fold the product into tens plus units
// (two stages), an adder tree merges the lane values (one stage), a three
// stage restoring remainder pipeline reduces the sum by the modulus, and the
// output register holds the check digit and the comparison with the digit at
// the configured position. Every stage carries its own valid bit and moves
// whenever the stage after it is free, so bubbles close up and new requests
// keep entering while a finished result waits for res_ready, until every
// stage is full. The registers are written over the APB-style port at byte
// addresses 0 (modulus), 8 (weight table), 16 (cross sum enable) and 24
// (check position); they must only be changed while no request is in flight.
// A modulus of zero or one gives a check digit of zero, and a check position
// outside one to ten always reports a failed check.
module weighted_modulus_check_digit (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	// Request channel.
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [3:0]  digit_0,
	input  logic [3:0]  digit_1,
	input  logic [3:0]  digit_2,
	input  logic [3:0]  digit_3,
	input  logic [3:0]  digit_4,
	input  logic [3:0]  digit_5,
	input  logic [3:0]  digit_6,
	input  logic [3:0]  digit_7,
	input  logic [3:0]  digit_8,
	input  logic [3:0]  digit_9,
	// Result channel.
	output logic        res_valid,
	input  logic        res_ready,
	output logic        valid_res,
	output logic [3:0]  computed_check
);

	localparam int NUM_STAGES = 7;
	localparam int ND         = wmcd_pkg::NUM_DIGITS;

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	logic [wmcd_pkg::MOD_W-1:0]  modulus_q;
	logic [wmcd_pkg::WTAB_W-1:0] weights_q;
	logic                        cross_en_q;
	logic [wmcd_pkg::POS_W-1:0]  check_pos_q;
	logic                        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q   <= 4'd10;
			weights_q   <= '0;
			cross_en_q  <= 1'b0;
			check_pos_q <= 4'd10;
		end else if (cfg_wr) begin
			case (paddr[4:3])
				wmcd_pkg::REG_MODULUS:   modulus_q   <= pwdata[wmcd_pkg::MOD_W-1:0];
				wmcd_pkg::REG_WEIGHTS:   weights_q   <= pwdata[wmcd_pkg::WTAB_W-1:0];
				wmcd_pkg::REG_CROSS_SUM: cross_en_q  <= pwdata[0];
				wmcd_pkg::REG_CHECK_POS: check_pos_q <= pwdata[wmcd_pkg::POS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			wmcd_pkg::REG_MODULUS:   prdata = 64'(modulus_q);
			wmcd_pkg::REG_WEIGHTS:   prdata = 64'(weights_q);
			wmcd_pkg::REG_CROSS_SUM: prdata = 64'(cross_en_q);
			wmcd_pkg::REG_CHECK_POS: prdata = 64'(check_pos_q);
			default:                 prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Pipeline flow control. A stage advances when it is empty or when the
	// stage after it advances; the last stage advances when its result is
	// taken or when it is empty.
	// ------------------------------------------------------------------
	logic [NUM_STAGES:1] busy_q;
	logic [NUM_STAGES:1] en;

	always_comb begin
		en[NUM_STAGES] = !busy_q[NUM_STAGES] || res_ready;
		for (int k = NUM_STAGES - 1; k >= 1; k--) begin
			en[k] = !busy_q[k] || en[k+1];
		end
	end

	assign req_ready = en[1];
	assign res_valid = busy_q[NUM_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else begin
			if (en[1]) begin
				busy_q[1] <= req_valid;
			end
			for (int k = 2; k <= NUM_STAGES; k++) begin
				if (en[k]) begin
					busy_q[k] <= busy_q[k-1];
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Reference digit. The digit at the check position is picked on entry
	// and travels alongside the arithmetic.
	// ------------------------------------------------------------------
	logic [wmcd_pkg::DIGIT_W-1:0] digit_a [ND];
	logic [wmcd_pkg::POS_W-1:0]   pos_idx;
	wmcd_pkg::chk_ref_t           chk_in;
	wmcd_pkg::chk_ref_t           chk_s [1:NUM_STAGES-1];

	assign digit_a[0] = digit_0;
	assign digit_a[1] = digit_1;
	assign digit_a[2] = digit_2;
	assign digit_a[3] = digit_3;
	assign digit_a[4] = digit_4;
	assign digit_a[5] = digit_5;
	assign digit_a[6] = digit_6;
	assign digit_a[7] = digit_7;
	assign digit_a[8] = digit_8;
	assign digit_a[9] = digit_9;

	always_comb begin
		pos_idx      = check_pos_q - wmcd_pkg::POS_FIRST;
		chk_in.ok    = (check_pos_q >= wmcd_pkg::POS_FIRST) &&
		               (check_pos_q <= wmcd_pkg::POS_LAST);
		chk_in.digit = chk_in.ok ? digit_a[pos_idx] : '0;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			chk_s[1] <= chk_in;
		end
		for (int k = 2; k < NUM_STAGES; k++) begin
			if (en[k]) begin
				chk_s[k] <= chk_s[k-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// Lanes: stages 1 and 2.
	// ------------------------------------------------------------------
	wmcd_pkg::lane_ctl_t  lane_ctl;
	wmcd_pkg::lane_vals_t lane_vals;

	assign lane_ctl.en_s1 = en[1];
	assign lane_ctl.en_s2 = en[2];

	for (genvar g = 0; g < ND; g++) begin : g_lane
		wmcd_lane u_lane (
			.clk      (clk),
			.ctl      (lane_ctl),
			.digit    (digit_a[g]),
			.weight   (weights_q[g*wmcd_pkg::WEIGHT_W +: wmcd_pkg::WEIGHT_W]),
			.cross_en (cross_en_q),
			.value_s2 (lane_vals[g])
		);
	end

	// ------------------------------------------------------------------
	// Merging adder tree: stage 3.
	// ------------------------------------------------------------------
	logic [wmcd_pkg::SUM_W-1:0] sum_s3;

	wmcd_merge u_merge (
		.clk    (clk),
		.en     (en[3]),
		.vals   (lane_vals),
		.sum_s3 (sum_s3)
	);

	// ------------------------------------------------------------------
	// Remainder pipeline: stages 4 to 6, twelve restoring steps in all.
	// With a zero modulus the steps subtract nothing; that case is taken
	// care of below.
	// ------------------------------------------------------------------
	logic [wmcd_pkg::SUM_W-1:0] rem_s4;
	logic [wmcd_pkg::SUM_W-1:0] rem_s5;
	logic [wmcd_pkg::SUM_W-1:0] rem_s6;

	wmcd_rem_step #(.SHIFT_HI(11)) u_rem_s4 (
		.clk (clk), .en (en[4]), .rem_in (sum_s3), .modulus (modulus_q), .rem_q (rem_s4)
	);

	wmcd_rem_step #(.SHIFT_HI(7)) u_rem_s5 (
		.clk (clk), .en (en[5]), .rem_in (rem_s4), .modulus (modulus_q), .rem_q (rem_s5)
	);

	wmcd_rem_step #(.SHIFT_HI(3)) u_rem_s6 (
		.clk (clk), .en (en[6]), .rem_in (rem_s5), .modulus (modulus_q), .rem_q (rem_s6)
	);

	// ------------------------------------------------------------------
	// Check digit and comparison: stage 7, the output register.
	// A remainder of zero counts as the modulus, so the difference
	// modulus minus remainder is at most fourteen and one conditional
	// subtraction of ten reduces it.
	// ------------------------------------------------------------------
	logic [wmcd_pkg::MOD_W-1:0]   rem_fin;
	logic [wmcd_pkg::MOD_W-1:0]   diff;
	logic [wmcd_pkg::DIGIT_W-1:0] check;
	logic                         valid_res_s7;
	logic [wmcd_pkg::DIGIT_W-1:0] check_s7;

	always_comb begin
		rem_fin = (modulus_q == '0) ? '0 : rem_s6[wmcd_pkg::MOD_W-1:0];
		if (rem_fin == '0) begin
			rem_fin = modulus_q;
		end
		diff  = modulus_q - rem_fin;
		check = (diff >= wmcd_pkg::CHECK_BASE) ? diff - wmcd_pkg::CHECK_BASE : diff;
	end

	always_ff @(posedge clk) begin
		if (en[NUM_STAGES]) begin
			check_s7     <= check;
			valid_res_s7 <= chk_s[NUM_STAGES-1].ok &&
			                (chk_s[NUM_STAGES-1].digit == check);
		end
	end

	assign valid_res      = valid_res_s7;
	assign computed_check = check_s7;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------

	// An empty output register means every stage can move, so requests flow.
	assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q[NUM_STAGES] |-> req_ready)
		else $error("request refused while the output stage is empty");

	// The remainder pipeline must leave a value below a nonzero modulus.
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q[NUM_STAGES-1] && (modulus_q != '0) |-> (rem_s6 < 12'(modulus_q)))
		else $error("remainder not reduced below the modulus");

	// The check digit is always a decimal digit.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (computed_check < wmcd_pkg::CHECK_BASE))
		else $error("check digit out of decimal range");

	// A pass can only be reported for a check position inside the number.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && valid_res |->
			(check_pos_q >= wmcd_pkg::POS_FIRST) && (check_pos_q <= wmcd_pkg::POS_LAST))
		else $error("pass reported for a check position outside the number");

endmodule
